// ===== hdl/ccg_pkg.sv =====
// shared types and constants of the click gesture classifier
// no dependencies
package ccg_pkg;

  localparam int KEY_W     = 16;
  localparam int CODE_W    = 8;
  localparam int TERM_W    = 8;
  localparam int QUIET_W   = 16;
  localparam int ACT_W     = 3;
  localparam int REQ_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int RES_N_W   = 2;

  localparam logic [RES_N_W-1:0] MAX_RESULTS = 2'd3;

  localparam logic [REQ_W-1:0] REQ_KEY  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MOVE = 2'd2;

  localparam logic [ACT_W-1:0] ACT_VERDICT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_TAP     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PRESS   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_KEY_TAP = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MODE_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_TERM_MS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK_KEY     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_KEY_A    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_KEY_B    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_KEY_C    = 3'd5;

  localparam logic              MODE_ENABLE_RST   = 1'b1;
  localparam logic [TERM_W-1:0] QUIET_TERM_MS_RST = 8'd60;
  localparam logic [KEY_W-1:0]  CLICK_KEY_RST     = 16'h000D;
  localparam logic [KEY_W-1:0]  HOLD_KEY_A_RST    = 16'h2207;
  localparam logic [KEY_W-1:0]  HOLD_KEY_B_RST    = 16'h2150;
  localparam logic [KEY_W-1:0]  HOLD_KEY_C_RST    = 16'h440E;

  localparam logic [QUIET_W-1:0] QUIET_MAX = 16'hFFFF;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic              pass_on;
    logic              button;
    logic [CODE_W-1:0] key_byte;
    logic              mouse_active;
    logic              last;
  } res_t;

  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

endpackage

// ===== hdl/ccg_in_if.sv =====
// input channel of the click gesture classifier
// depends on ccg_pkg
interface ccg_in_if;
  logic                       valid;
  logic                       ready;
  logic [ccg_pkg::REQ_W-1:0]  req_type;
  logic [ccg_pkg::KEY_W-1:0]  key_code;
  logic                       key_down;
  logic                       moved;

  modport source (output valid, req_type, key_code, key_down, moved, input ready);
  modport sink (input valid, req_type, key_code, key_down, moved, output ready);
endinterface

// ===== hdl/ccg_out_if.sv =====
// result channel of the click gesture classifier
// depends on ccg_pkg
interface ccg_out_if;
  logic                        valid;
  logic                        ready;
  logic [ccg_pkg::ACT_W-1:0]   action;
  logic                        pass_on;
  logic                        button;
  logic [ccg_pkg::CODE_W-1:0]  key_byte;
  logic                        mouse_active;
  logic                        last;

  modport source (output valid, action, pass_on, button, key_byte, mouse_active, last,
                  input ready);
  modport sink (input valid, action, pass_on, button, key_byte, mouse_active, last,
                output ready);
endinterface

// ===== hdl/ccg_cfg_if.sv =====
// register write channel of the click gesture classifier
// depends on ccg_pkg
interface ccg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ccg_pkg::CFG_IDX_W-1:0]  index;
  logic [ccg_pkg::CFG_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/ccg_cmp.sv =====
// shared 16-bit compare unit: equality and unsigned less-than
// depends on ccg_pkg
module ccg_cmp (
  input  logic [ccg_pkg::KEY_W-1:0] a,
  input  logic [ccg_pkg::KEY_W-1:0] b,
  output ccg_pkg::cmp_res_t         res
);

  always_comb begin
    res.eq = (a == b);
    res.lt = (a < b);
  end

endmodule

// ===== hdl/ccg_obuf.sv =====
// output register stage of the result channel
// depends on ccg_pkg and ccg_out_if
module ccg_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ld_valid,
  input  ccg_pkg::res_t     ld_res,
  output logic              ld_ready,
  ccg_out_if.source         out_if
);

  logic          valid_r;
  ccg_pkg::res_t res_r;

  assign ld_ready = !valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ld_ready) begin
      valid_r <= ld_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_valid && ld_ready) begin
      res_r <= ld_res;
    end
  end

  assign out_if.valid        = valid_r;
  assign out_if.action       = res_r.action;
  assign out_if.pass_on      = res_r.pass_on;
  assign out_if.button       = res_r.button;
  assign out_if.key_byte     = res_r.key_byte;
  assign out_if.mouse_active = res_r.mouse_active;
  assign out_if.last         = res_r.last;

endmodule

// ===== hdl/click_gesture_classifier.sv =====
// click gesture classifier top level: sequencer, state and buffer around a shared comparator
// sequence: key event KCMP (hold and click keys), KEY, KB0 if buffering, EMIT; tick CLS0,
// then CLS1, CLS2, SCAN as needed, EMIT; pointer reports and unused types stay in IDLE
// throughput: one transaction at a time, ready again after its last result is in the output reg
// reset: rst_n synchronous active low, restores registers and empties the buffer at once
// depends on ccg_pkg, ccg_in_if, ccg_out_if, ccg_cfg_if, ccg_cmp, ccg_obuf
module click_gesture_classifier #(
  parameter int BUFFER_DEPTH = 3
) (
  input  logic      clk,
  input  logic      rst_n,
  ccg_in_if.sink    in_if,
  ccg_out_if.source out_if,
  ccg_cfg_if.sink   cfg_if
);

  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int IDX_W = $clog2(BUFFER_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUFFER_DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_KCMP = 4'd1;
  localparam logic [3:0] S_KEY  = 4'd2;
  localparam logic [3:0] S_KB0  = 4'd3;
  localparam logic [3:0] S_CLS0 = 4'd4;
  localparam logic [3:0] S_CLS1 = 4'd5;
  localparam logic [3:0] S_CLS2 = 4'd6;
  localparam logic [3:0] S_SCAN = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  localparam int KW = ccg_pkg::KEY_W;
  localparam int CW = ccg_pkg::CODE_W;
  localparam int AW = ccg_pkg::ACT_W;
  localparam int NW = ccg_pkg::RES_N_W;

  // configuration
  logic                       mode_r;
  logic [ccg_pkg::TERM_W-1:0] term_r;
  logic [KW-1:0]              click_key_r, hold_a_r, hold_b_r, hold_c_r;

  // control
  logic [3:0]    state_r, state_nxt;
  logic [1:0]    step_r, step_nxt;
  logic          hold_hit_r, hold_hit_nxt;
  logic          click_hit_r, click_hit_nxt;
  logic          modifier_r, modifier_nxt;
  logic          pointer_r, pointer_nxt;
  logic          drag_r, drag_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ccg_pkg::QUIET_W-1:0] quiet_r, quiet_nxt;
  logic [IDX_W-1:0] scan_r, scan_nxt;
  logic [NW-1:0] res_n_r, res_n_nxt;
  logic [NW-1:0] emit_r, emit_nxt;

  // payload
  logic [KW-1:0] key_code_r;
  logic          key_down_r;
  logic [CW-1:0] buf_code_r [BUFFER_DEPTH];
  logic          buf_down_r [BUFFER_DEPTH];
  logic          buf_we;
  logic [AW-1:0] res_act_r [3], res_act_nxt [3];
  logic          res_pass_r [3], res_pass_nxt [3];
  logic [CW-1:0] res_code_r [3], res_code_nxt [3];

  logic              in_acc;
  logic              mod_v, pr_v;
  logic [KW-1:0]     cmp_a, cmp_b;
  ccg_pkg::cmp_res_t cmp;
  logic              ld_valid, ld_ready;
  ccg_pkg::res_t     ld_res;

  assign in_if.ready  = (state_r == S_IDLE);
  assign in_acc       = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  ccg_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp)
  );

  ccg_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld_valid (ld_valid),
    .ld_res   (ld_res),
    .ld_ready (ld_ready),
    .out_if   (out_if)
  );

  // operand select of the shared comparator
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    unique case (state_r)
      S_KCMP: begin
        cmp_a = key_code_r;
        unique case (step_r)
          2'd0:    cmp_b = hold_a_r;
          2'd1:    cmp_b = hold_b_r;
          2'd2:    cmp_b = hold_c_r;
          default: cmp_b = click_key_r;
        endcase
      end
      S_KB0, S_CLS1: begin
        cmp_a = KW'(buf_code_r[0]);
        cmp_b = click_key_r;
      end
      S_CLS0: begin
        cmp_a = quiet_r;
        cmp_b = KW'(term_r);
      end
      S_CLS2: begin
        cmp_a = KW'(buf_code_r[2]);
        cmp_b = KW'(buf_code_r[0]);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    hold_hit_nxt  = hold_hit_r;
    click_hit_nxt = click_hit_r;
    modifier_nxt  = modifier_r;
    pointer_nxt   = pointer_r;
    drag_nxt      = drag_r;
    cnt_nxt       = cnt_r;
    quiet_nxt     = quiet_r;
    scan_nxt      = scan_r;
    res_n_nxt     = res_n_r;
    emit_nxt      = emit_r;
    res_act_nxt   = res_act_r;
    res_pass_nxt  = res_pass_r;
    res_code_nxt  = res_code_r;
    buf_we        = 1'b0;
    ld_valid      = 1'b0;
    mod_v         = modifier_r;
    pr_v          = pointer_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_n_nxt = '0;
          emit_nxt  = '0;
          unique case (in_if.req_type)
            ccg_pkg::REQ_KEY: begin
              state_nxt    = S_KCMP;
              step_nxt     = 2'd0;
              hold_hit_nxt = 1'b0;
            end
            ccg_pkg::REQ_TICK: begin
              if (quiet_r != ccg_pkg::QUIET_MAX) begin
                quiet_nxt = quiet_r + 1'b1;
              end
              state_nxt = S_CLS0;
            end
            ccg_pkg::REQ_MOVE: begin
              if (in_if.moved) begin
                pointer_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      S_KCMP: begin
        if (step_r == 2'd3) begin
          click_hit_nxt = cmp.eq;
          state_nxt     = S_KEY;
        end else begin
          hold_hit_nxt = hold_hit_r | cmp.eq;
          step_nxt     = step_r + 2'd1;
        end
      end

      S_KEY: begin
        if (hold_hit_r && !key_down_r) begin
          modifier_nxt    = 1'b0;
          res_act_nxt[0]  = ccg_pkg::ACT_VERDICT;
          res_pass_nxt[0] = 1'b1;
          res_code_nxt[0] = '0;
          res_n_nxt       = 2'd1;
          state_nxt       = S_EMIT;
        end else begin
          mod_v        = hold_hit_r ? 1'b1 : modifier_r;
          modifier_nxt = mod_v;
          pr_v         = (!click_hit_r && !mod_v) ? 1'b0 : pointer_r;
          pointer_nxt  = pr_v;
          if (drag_r && click_hit_r && !key_down_r) begin
            // drag ends on click key release
            res_act_nxt[0]  = ccg_pkg::ACT_RELEASE;
            res_pass_nxt[0] = 1'b0;
            res_code_nxt[0] = '0;
            res_act_nxt[1]  = ccg_pkg::ACT_VERDICT;
            res_pass_nxt[1] = 1'b0;
            res_code_nxt[1] = '0;
            res_n_nxt       = 2'd2;
            drag_nxt        = 1'b0;
            cnt_nxt         = '0;
            state_nxt       = S_EMIT;
          end else begin
            quiet_nxt = '0;
            if (mode_r && (pr_v || cnt_r != '0)) begin
              if (cnt_r < DEPTH_C) begin
                buf_we  = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
              state_nxt = S_KB0;
            end else begin
              res_act_nxt[0]  = ccg_pkg::ACT_VERDICT;
              res_pass_nxt[0] = 1'b1;
              res_code_nxt[0] = '0;
              res_n_nxt       = 2'd1;
              state_nxt       = S_EMIT;
            end
          end
        end
      end

      S_KB0: begin
        res_act_nxt[0]  = ccg_pkg::ACT_VERDICT;
        res_pass_nxt[0] = !(cmp.eq && key_down_r);
        res_code_nxt[0] = '0;
        res_n_nxt       = 2'd1;
        state_nxt       = S_EMIT;
      end

      S_CLS0: begin
        if (!mode_r || cnt_r == '0) begin
          state_nxt = S_EMIT;
        end else if (cmp.lt && cnt_r < DEPTH_C) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_CLS1;
        end
      end

      S_CLS1: begin
        if (cmp.eq && buf_down_r[0]) begin
          state_nxt = S_CLS2;
        end else begin
          cnt_nxt   = '0;
          state_nxt = S_EMIT;
        end
      end

      S_CLS2: begin
        priority if (cnt_r >= CNT_W'(3) && !buf_down_r[1] && buf_down_r[2] && cmp.eq) begin
          // double click
          res_act_nxt[0]  = ccg_pkg::ACT_TAP;
          res_pass_nxt[0] = 1'b0;
          res_code_nxt[0] = '0;
          res_act_nxt[1]  = ccg_pkg::ACT_TAP;
          res_pass_nxt[1] = 1'b0;
          res_code_nxt[1] = '0;
          res_n_nxt       = 2'd2;
          cnt_nxt         = '0;
          state_nxt       = S_EMIT;
        end else if (cnt_r == CNT_W'(1)) begin
          res_act_nxt[0]  = ccg_pkg::ACT_PRESS;
          res_pass_nxt[0] = 1'b0;
          res_code_nxt[0] = '0;
          res_n_nxt       = 2'd1;
          drag_nxt        = 1'b1;
          cnt_nxt         = '0;
          state_nxt       = S_EMIT;
        end else if (cnt_r >= CNT_W'(2) && !buf_down_r[1]) begin
          res_act_nxt[0]  = ccg_pkg::ACT_TAP;
          res_pass_nxt[0] = 1'b0;
          res_code_nxt[0] = '0;
          res_n_nxt       = 2'd1;
          cnt_nxt         = '0;
          state_nxt       = S_EMIT;
        end else begin
          scan_nxt  = '0;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        // replay buffered presses, one entry per cycle
        if (buf_down_r[scan_r] && res_n_r != ccg_pkg::MAX_RESULTS) begin
          res_act_nxt[res_n_r]  = ccg_pkg::ACT_KEY_TAP;
          res_pass_nxt[res_n_r] = 1'b0;
          res_code_nxt[res_n_r] = buf_code_r[scan_r];
          res_n_nxt             = res_n_r + 2'd1;
        end
        if ((CNT_W'(scan_r) + CNT_W'(1)) == cnt_r) begin
          cnt_nxt   = '0;
          state_nxt = S_EMIT;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      S_EMIT: begin
        if (res_n_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          ld_valid = 1'b1;
          if (ld_ready) begin
            if (emit_r == res_n_r - 2'd1) begin
              state_nxt = S_IDLE;
            end else begin
              emit_nxt = emit_r + 2'd1;
            end
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ld_res.action       = res_act_r[emit_r];
    ld_res.pass_on      = res_pass_r[emit_r];
    ld_res.button       = 1'b0;
    ld_res.key_byte     = res_code_r[emit_r];
    ld_res.mouse_active = mode_r & pointer_r;
    ld_res.last         = (emit_r == res_n_r - 2'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= ccg_pkg::MODE_ENABLE_RST;
      term_r      <= ccg_pkg::QUIET_TERM_MS_RST;
      click_key_r <= ccg_pkg::CLICK_KEY_RST;
      hold_a_r    <= ccg_pkg::HOLD_KEY_A_RST;
      hold_b_r    <= ccg_pkg::HOLD_KEY_B_RST;
      hold_c_r    <= ccg_pkg::HOLD_KEY_C_RST;
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        ccg_pkg::REG_MODE_ENABLE:   mode_r      <= cfg_if.data[0];
        ccg_pkg::REG_QUIET_TERM_MS: term_r      <= cfg_if.data[ccg_pkg::TERM_W-1:0];
        ccg_pkg::REG_CLICK_KEY:     click_key_r <= cfg_if.data;
        ccg_pkg::REG_HOLD_KEY_A:    hold_a_r    <= cfg_if.data;
        ccg_pkg::REG_HOLD_KEY_B:    hold_b_r    <= cfg_if.data;
        ccg_pkg::REG_HOLD_KEY_C:    hold_c_r    <= cfg_if.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      hold_hit_r  <= 1'b0;
      click_hit_r <= 1'b0;
      modifier_r  <= 1'b0;
      pointer_r   <= 1'b0;
      drag_r      <= 1'b0;
      cnt_r       <= '0;
      quiet_r     <= '0;
      scan_r      <= '0;
      res_n_r     <= '0;
      emit_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      hold_hit_r  <= hold_hit_nxt;
      click_hit_r <= click_hit_nxt;
      modifier_r  <= modifier_nxt;
      pointer_r   <= pointer_nxt;
      drag_r      <= drag_nxt;
      cnt_r       <= cnt_nxt;
      quiet_r     <= quiet_nxt;
      scan_r      <= scan_nxt;
      res_n_r     <= res_n_nxt;
      emit_r      <= emit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_code_r <= in_if.key_code;
      key_down_r <= in_if.key_down;
    end
    if (buf_we) begin
      buf_code_r[cnt_r[IDX_W-1:0]] <= key_code_r[CW-1:0];
      buf_down_r[cnt_r[IDX_W-1:0]] <= key_down_r;
    end
    res_act_r  <= res_act_nxt;
    res_pass_r <= res_pass_nxt;
    res_code_r <= res_code_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("buffer count beyond depth");

  a_drag_from_cls: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(drag_r) |-> $past(state_r) == S_CLS2)
    else $error("drag started outside classification");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ld_valid && ld_ready && ld_res.last) |=> state_r == S_IDLE)
    else $error("final result not followed by idle");

  a_key_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_if.req_type == ccg_pkg::REQ_KEY) |=> (state_r == S_KCMP && step_r == 2'd0))
    else $error("key transaction did not start compare sweep");

  a_res_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && res_n_r != '0) |-> emit_r < res_n_r)
    else $error("emit index past result count");

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for click_gesture_classifier: directed and random key, tick and
// pointer traffic, random idling on input and output channels, checked by a built-in predictor
// depends on ccg_pkg, ccg_in_if, ccg_out_if, ccg_cfg_if and the block's rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUF_DEPTH = 3;
  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT = 4000;
  localparam logic [ccg_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef enum int {G_SINGLE, G_DOUBLE, G_DRAG, G_REPLAY, G_HELD, G_LOOSE} gesture_t;

  class gesture_tracker_t;
    logic                         mode_en;
    logic [ccg_pkg::TERM_W-1:0]   quiet_term;
    logic [ccg_pkg::KEY_W-1:0]    click_key;
    logic [ccg_pkg::KEY_W-1:0]    hold_a;
    logic [ccg_pkg::KEY_W-1:0]    hold_b;
    logic [ccg_pkg::KEY_W-1:0]    hold_c;
    logic                         modifier_held;
    logic                         pointer_recent;
    logic                         drag_active;
    int unsigned                  buf_cnt;
    logic [ccg_pkg::CODE_W-1:0]   buf_code [BUF_DEPTH];
    logic                         buf_down [BUF_DEPTH];
    logic [ccg_pkg::QUIET_W-1:0]  quiet_ms;
    ccg_pkg::res_t                step_results[$];
    ccg_pkg::res_t                pending_actions[$];
    int                           mismatch_count;

    function new();
      mode_en = ccg_pkg::MODE_ENABLE_RST;
      quiet_term = ccg_pkg::QUIET_TERM_MS_RST;
      click_key = ccg_pkg::CLICK_KEY_RST;
      hold_a = ccg_pkg::HOLD_KEY_A_RST;
      hold_b = ccg_pkg::HOLD_KEY_B_RST;
      hold_c = ccg_pkg::HOLD_KEY_C_RST;
      modifier_held = 1'b0;
      pointer_recent = 1'b0;
      drag_active = 1'b0;
      buf_cnt = 0;
      quiet_ms = '0;
      mismatch_count = 0;
    endfunction

    function void set_reg(logic [ccg_pkg::CFG_IDX_W-1:0] idx, logic [ccg_pkg::CFG_W-1:0] data);
      case (idx)
        ccg_pkg::REG_MODE_ENABLE:   mode_en = data[0];
        ccg_pkg::REG_QUIET_TERM_MS: quiet_term = data[ccg_pkg::TERM_W-1:0];
        ccg_pkg::REG_CLICK_KEY:     click_key = data;
        ccg_pkg::REG_HOLD_KEY_A:    hold_a = data;
        ccg_pkg::REG_HOLD_KEY_B:    hold_b = data;
        ccg_pkg::REG_HOLD_KEY_C:    hold_c = data;
        default: ;
      endcase
    endfunction

    function void emit(logic [ccg_pkg::ACT_W-1:0] act, logic pass,
                       logic [ccg_pkg::CODE_W-1:0] code);
      ccg_pkg::res_t r;
      r = '0;
      r.action = act;
      r.pass_on = pass;
      r.key_byte = code;
      step_results.push_back(r);
    endfunction

    function void key_event(logic [ccg_pkg::KEY_W-1:0] kc, logic kd);
      if (kc == hold_a || kc == hold_b || kc == hold_c) begin
        if (kd) begin
          modifier_held = 1'b1;
        end else begin
          modifier_held = 1'b0;
          emit(ccg_pkg::ACT_VERDICT, 1'b1, '0);
          return;
        end
      end
      if (kc != click_key && !modifier_held) pointer_recent = 1'b0;
      if (drag_active && kc == click_key && !kd) begin
        emit(ccg_pkg::ACT_RELEASE, 1'b0, '0);
        drag_active = 1'b0;
        buf_cnt = 0;
        emit(ccg_pkg::ACT_VERDICT, 1'b0, '0);
        return;
      end
      quiet_ms = '0;
      if (mode_en && (pointer_recent || buf_cnt > 0)) begin
        if (buf_cnt < BUF_DEPTH) begin
          buf_code[buf_cnt] = kc[ccg_pkg::CODE_W-1:0];
          buf_down[buf_cnt] = kd;
          buf_cnt++;
        end
        if (buf_code[0] == click_key && kd) begin
          emit(ccg_pkg::ACT_VERDICT, 1'b0, '0);
          return;
        end
      end
      emit(ccg_pkg::ACT_VERDICT, 1'b1, '0);
    endfunction

    function void classify_buffer();
      int i;
      if (!mode_en || buf_cnt == 0) return;
      if (quiet_ms < quiet_term && buf_cnt < BUF_DEPTH) return;
      if (buf_code[0] == click_key && buf_down[0]) begin
        if (buf_cnt >= 3 && !buf_down[1] && buf_down[2] && buf_code[2] == buf_code[0]) begin
          emit(ccg_pkg::ACT_TAP, 1'b0, '0);
          emit(ccg_pkg::ACT_TAP, 1'b0, '0);
        end else if (buf_cnt == 1) begin
          emit(ccg_pkg::ACT_PRESS, 1'b0, '0);
          drag_active = 1'b1;
        end else if (!buf_down[1]) begin
          emit(ccg_pkg::ACT_TAP, 1'b0, '0);
        end else begin
          for (i = 0; i < buf_cnt; i++)
            if (buf_down[i]) emit(ccg_pkg::ACT_KEY_TAP, 1'b0, buf_code[i]);
        end
      end
      buf_cnt = 0;
    endfunction

    function void note_request(logic [ccg_pkg::REQ_W-1:0] rt, logic [ccg_pkg::KEY_W-1:0] kc,
                               logic kd, logic mv);
      ccg_pkg::res_t r;
      step_results.delete();
      case (rt)
        ccg_pkg::REQ_KEY: key_event(kc, kd);
        ccg_pkg::REQ_TICK: begin
          if (quiet_ms != ccg_pkg::QUIET_MAX) quiet_ms++;
          classify_buffer();
        end
        ccg_pkg::REQ_MOVE: if (mv) pointer_recent = 1'b1;
        default: ;
      endcase
      foreach (step_results[i]) begin
        r = step_results[i];
        r.mouse_active = mode_en & pointer_recent;
        r.last = (i == step_results.size() - 1);
        pending_actions.push_back(r);
      end
    endfunction

    task flag_mismatch(string what, int got, int want);
      $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatch_count++;
    endtask

    task check_action(ccg_pkg::res_t got);
      ccg_pkg::res_t want;
      if (pending_actions.size() == 0) begin
        flag_mismatch("unexpected result action", got.action, 0);
        return;
      end
      want = pending_actions.pop_front();
      if (got.action !== want.action) flag_mismatch("action", got.action, want.action);
      if (got.pass_on !== want.pass_on) flag_mismatch("pass_on", got.pass_on, want.pass_on);
      if (got.button !== want.button) flag_mismatch("button", got.button, want.button);
      if (got.key_byte !== want.key_byte)
        flag_mismatch("key_byte", got.key_byte, want.key_byte);
      if (got.mouse_active !== want.mouse_active)
        flag_mismatch("mouse_active", got.mouse_active, want.mouse_active);
      if (got.last !== want.last) flag_mismatch("last", got.last, want.last);
    endtask
  endclass

  logic clk;
  logic rst_n;

  ccg_in_if  in_ch();
  ccg_out_if out_ch();
  ccg_cfg_if cfg_ch();

  click_gesture_classifier #(.BUFFER_DEPTH(BUF_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  gesture_tracker_t tracker = new();
  int  requests_sent = 0;
  int  quiet_cycles = 0;
  int  stall_left = 0;
  bit  in_steady = 0;
  bit  out_steady = 0;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [ccg_pkg::KEY_W-1:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return tracker.click_key;
    if (r < 45) begin
      case ($urandom_range(0, 2))
        0: return tracker.hold_a;
        1: return tracker.hold_b;
        default: return tracker.hold_c;
      endcase
    end
    if (r < 60) return {8'($urandom), tracker.click_key[ccg_pkg::CODE_W-1:0]};
    return 16'($urandom);
  endfunction

  // result sink with random backpressure
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.check_action({out_ch.action, out_ch.pass_on, out_ch.button, out_ch.key_byte,
                            out_ch.mouse_active, out_ch.last});
    if ($urandom_range(0, 79) == 0) out_steady = !out_steady;
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      if (!out_steady && $urandom_range(0, 99) < 25) stall_left = idle_length();
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else if (++quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_req(logic [ccg_pkg::REQ_W-1:0] rt, logic [ccg_pkg::KEY_W-1:0] kc,
                          logic kd, logic mv);
    int gap;
    gap = (in_steady || $urandom_range(0, 99) < 45) ? 0 : idle_length();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= rt;
    in_ch.key_code <= kc;
    in_ch.key_down <= kd;
    in_ch.moved <= mv;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_request(rt, kc, kd, mv);
    requests_sent++;
  endtask

  task automatic send_key(logic [ccg_pkg::KEY_W-1:0] kc, logic kd);
    send_req(ccg_pkg::REQ_KEY, kc, kd, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_tick();
    send_req(ccg_pkg::REQ_TICK, 16'($urandom), 1'($urandom_range(0, 1)),
             1'($urandom_range(0, 1)));
  endtask

  task automatic send_move(logic mv);
    send_req(ccg_pkg::REQ_MOVE, 16'($urandom), 1'($urandom_range(0, 1)), mv);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (tracker.pending_actions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [ccg_pkg::CFG_IDX_W-1:0] idx, logic [ccg_pkg::CFG_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    tracker.set_reg(idx, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(logic mode, logic [ccg_pkg::TERM_W-1:0] term,
                              logic [ccg_pkg::KEY_W-1:0] ck,
                              logic [ccg_pkg::KEY_W-1:0] ha, logic [ccg_pkg::KEY_W-1:0] hb,
                              logic [ccg_pkg::KEY_W-1:0] hc);
    logic [ccg_pkg::CFG_W-1:0] d;
    drain();
    d = 16'($urandom);
    d[0] = mode;
    write_reg(ccg_pkg::REG_MODE_ENABLE, d);
    d = 16'($urandom);
    d[ccg_pkg::TERM_W-1:0] = term;
    write_reg(ccg_pkg::REG_QUIET_TERM_MS, d);
    write_reg(ccg_pkg::REG_CLICK_KEY, ck);
    write_reg(ccg_pkg::REG_HOLD_KEY_A, ha);
    write_reg(ccg_pkg::REG_HOLD_KEY_B, hb);
    write_reg(ccg_pkg::REG_HOLD_KEY_C, hc);
  endtask

  task automatic run_gesture();
    logic [ccg_pkg::KEY_W-1:0] ck;
    logic [ccg_pkg::KEY_W-1:0] other;
    logic [ccg_pkg::KEY_W-1:0] hold;
    gesture_t kind;
    int settle;
    ck = tracker.click_key;
    other = pick_code();
    hold = ($urandom_range(0, 1) != 0) ? tracker.hold_a : tracker.hold_c;
    kind = gesture_t'($urandom_range(0, 5));
    if ($urandom_range(0, 9) != 0) send_move(1'b1);
    case (kind)
      G_SINGLE: begin
        send_key(ck, 1'b1);
        send_key(ck, 1'b0);
      end
      G_DOUBLE: begin
        send_key(ck, 1'b1);
        send_key(ck, 1'b0);
        send_key(ck, 1'b1);
      end
      G_DRAG: send_key(ck, 1'b1);
      G_REPLAY: begin
        send_key(ck, 1'b1);
        send_key(other, 1'b1);
        send_key(pick_code(), 1'($urandom_range(0, 1)));
      end
      G_HELD: begin
        send_key(hold, 1'b1);
        send_key(ck, 1'b1);
        send_key(ck, 1'b0);
        send_key(hold, 1'b0);
      end
      default: begin
        repeat ($urandom_range(1, 4)) send_key(pick_code(), 1'($urandom_range(0, 1)));
      end
    endcase
    settle = (tracker.quiet_term <= 8) ? tracker.quiet_term + $urandom_range(1, 2)
                                        : $urandom_range(1, 3);
    repeat (settle) send_tick();
    if (kind == G_DRAG) begin
      if ($urandom_range(0, 1) != 0) send_key(other, 1'($urandom_range(0, 1)));
      send_key(ck, 1'b0);
    end
  endtask

  task automatic run_phase(int n);
    int stop_at;
    stop_at = requests_sent + n;
    while (requests_sent < stop_at) begin
      in_steady = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) < 7) run_gesture();
      else send_req(2'($urandom_range(0, 3)), pick_code(), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = ccg_pkg::REQ_KEY;
    in_ch.key_code = '0;
    in_ch.key_down = 1'b0;
    in_ch.moved = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = ccg_pkg::REG_MODE_ENABLE;
    cfg_ch.data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration, no pointer movement yet
    send_key(ccg_pkg::CLICK_KEY_RST, 1'b1);
    send_key(16'h0000, 1'b0);
    send_req(REQ_UNUSED, 16'hFFFF, 1'b1, 1'b1);
    send_move(1'b0);
    // full buffer classifies at once: double click, key dropped when full
    send_move(1'b1);
    send_key(ccg_pkg::CLICK_KEY_RST, 1'b1);
    send_key(ccg_pkg::CLICK_KEY_RST, 1'b0);
    send_key(ccg_pkg::CLICK_KEY_RST, 1'b1);
    send_key(16'hFFFF, 1'b1);
    send_tick();
    // modifiers keep mouse mode alive, hold release passes and stops there
    send_move(1'b1);
    send_key(ccg_pkg::HOLD_KEY_A_RST, 1'b1);
    send_key(ccg_pkg::HOLD_KEY_B_RST, 1'b0);
    send_key(16'h4455, 1'b1);
    send_key(ccg_pkg::HOLD_KEY_C_RST, 1'b1);
    send_tick();
    // high byte ignored in the buffered compare, replay of presses
    send_move(1'b1);
    send_key(16'h010D, 1'b1);
    send_key(ccg_pkg::CLICK_KEY_RST, 1'b1);
    send_key(16'h0031, 1'b1);
    send_tick();

    apply_config(1'b1, 8'd0, ccg_pkg::CLICK_KEY_RST, ccg_pkg::HOLD_KEY_A_RST,
                 ccg_pkg::HOLD_KEY_B_RST, ccg_pkg::HOLD_KEY_C_RST);
    run_phase(45);
    apply_config(1'b1, 8'd3, {8'h00, 8'($urandom)}, 16'($urandom), 16'($urandom),
                 16'($urandom));
    run_phase(45);
    apply_config(1'b0, 8'($urandom_range(0, 5)), {8'h00, 8'($urandom)},
                 ccg_pkg::HOLD_KEY_A_RST, ccg_pkg::HOLD_KEY_B_RST, ccg_pkg::HOLD_KEY_C_RST);
    run_phase(30);
    apply_config(1'b1, 8'd255, 16'hFFFF, 16'h0000, 16'hFFFF, ccg_pkg::HOLD_KEY_C_RST);
    run_phase(40);
    apply_config(1'b1, 8'd2, 16'h0000, 16'hFFFF, 16'h0101, ccg_pkg::HOLD_KEY_A_RST);
    run_phase(45);
    apply_config(1'b1, 8'($urandom_range(1, 8)), {8'h00, 8'($urandom)}, 16'($urandom),
                 16'($urandom), 16'($urandom));
    run_phase(45);

    drain();
    if (tracker.mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== click_gesture_classifier.f =====
hdl/ccg_pkg.sv
hdl/ccg_in_if.sv
hdl/ccg_out_if.sv
hdl/ccg_cfg_if.sv
hdl/ccg_cmp.sv
hdl/ccg_obuf.sv
hdl/click_gesture_classifier.sv
tb/testbench.sv
